/* sv/double_ended_queue_macros.svh */
// Assertion macros used by the double-ended queue checker.
// Depends on nothing; included by the checker, which holds concurrent assertions.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define DQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("double_ended_queue: same-cycle check failed");

// Next-cycle implication, disabled while reset is high
`define DQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("double_ended_queue: next-cycle check failed");

`endif

/* sv/dq_pkg.sv */
// Package for the double-ended queue: default sizes, operation and status
// codes, and the request, result and control structs. Depends on nothing.
`default_nettype none

package dq_pkg;

  // Default sizes
  localparam int DQ_DEPTH      = 16;
  localparam int DQ_DATA_WIDTH = 32;

  // Fixed widths of the request and result fields
  localparam int DQ_WORD_W = 32;
  localparam int DQ_OCC_W  = 5;

  typedef enum logic [1:0] {
    DQ_PUSH_FRONT = 2'd0,
    DQ_PUSH_BACK  = 2'd1,
    DQ_POP_FRONT  = 2'd2,
    DQ_POP_BACK   = 2'd3
  } dq_func_t;

  typedef enum logic [1:0] {
    DQ_ST_DONE  = 2'd0,
    DQ_ST_FULL  = 2'd1,
    DQ_ST_EMPTY = 2'd2
  } dq_status_t;

  typedef struct packed {
    dq_func_t                     func;
    logic signed [DQ_WORD_W-1:0]  entry_data;
  } dq_req_t;

  typedef struct packed {
    logic signed [DQ_WORD_W-1:0]  front_data;
    logic signed [DQ_WORD_W-1:0]  back_data;
    logic [DQ_OCC_W-1:0]          occupancy;
    logic                         is_empty;
    dq_status_t                   status;
  } dq_result_t;

  // Controller to datapath
  typedef struct packed {
    logic exec;   // carry out the request on the ports
    logic load;   // capture the slot read into the end word
  } dq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_read;  // request is a pop that leaves one or more words
  } dq_stat_t;

endpackage

`default_nettype wire

/* sv/dq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/dq_ctrl.sv */
// Controller of the double-ended queue: sequences accept, slot read and
// result strobe. Depends on dq_pkg.
`default_nettype none

module dq_ctrl
  import dq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire dq_stat_t stat,
  output dq_cmd_t       cmd,
  output logic          busy,
  output logic          done
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_REPLY
  } state_t;

  state_t state;

  // State and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            if (stat.need_read) begin
              state <= S_LOAD;
            end else begin
              state <= S_REPLY;
              done  <= 1'b1;
            end
          end
        end
        S_LOAD: begin
          state <= S_REPLY;
          done  <= 1'b1;
        end
        S_REPLY: begin
          state <= S_IDLE;
          done  <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
          done  <= 1'b0;
        end
      endcase
    end
  end

  // Commands
  assign cmd.exec = (state == S_IDLE) && start;
  assign cmd.load = (state == S_LOAD);
  assign busy     = (state != S_IDLE);

endmodule

`default_nettype wire

/* sv/dq_datapath.sv */
// Datapath of the double-ended queue: ring indices, fill count, cached end
// words and the slot RAM. Depends on dq_pkg and dq_ram.
`default_nettype none

module dq_datapath
  import dq_pkg::*;
#(
  parameter int DEPTH      = DQ_DEPTH,
  parameter int DATA_WIDTH = DQ_DATA_WIDTH
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire dq_req_t request,
  input  wire dq_cmd_t cmd,
  output dq_stat_t     stat,
  output dq_result_t   result
);

  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [IDX_W-1:0]      first_idx, first_idx_next;
  logic [IDX_W-1:0]      last_idx, last_idx_next;
  logic [FILL_W-1:0]     fill, fill_next;
  logic [DATA_WIDTH-1:0] front_word, front_word_next;
  logic [DATA_WIDTH-1:0] back_word, back_word_next;
  logic                  load_front, load_front_next;
  dq_status_t            status_q, status_next;

  logic                  we;
  logic [IDX_W-1:0]      waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata, rdata;

  logic                  is_push, at_front, full, empty;
  logic [IDX_W-1:0]      first_inc, first_dec, last_inc, last_dec;

  // Decode and ring neighbors
  assign is_push  = (request.func == DQ_PUSH_FRONT) || (request.func == DQ_PUSH_BACK);
  assign at_front = (request.func == DQ_PUSH_FRONT) || (request.func == DQ_POP_FRONT);
  assign full     = (fill == FILL_W'(DEPTH));
  assign empty    = (fill == '0);

  assign first_inc = (first_idx == IDX_W'(DEPTH - 1)) ? '0 : first_idx + 1'b1;
  assign first_dec = (first_idx == '0) ? IDX_W'(DEPTH - 1) : first_idx - 1'b1;
  assign last_inc  = (last_idx == IDX_W'(DEPTH - 1)) ? '0 : last_idx + 1'b1;
  assign last_dec  = (last_idx == '0) ? IDX_W'(DEPTH - 1) : last_idx - 1'b1;

  // A pop that leaves one or more words must fetch the new end word
  assign stat.need_read = !is_push && !empty && (fill != FILL_W'(1));

  assign wdata = DATA_WIDTH'(request.entry_data);
  assign raddr = at_front ? first_inc : last_dec;

  // Next state of indices, count and end words
  always_comb begin
    first_idx_next  = first_idx;
    last_idx_next   = last_idx;
    fill_next       = fill;
    front_word_next = front_word;
    back_word_next  = back_word;
    load_front_next = load_front;
    status_next     = status_q;
    we              = 1'b0;
    waddr           = first_idx;

    if (cmd.exec) begin
      load_front_next = at_front;
      if (is_push) begin
        if (full) begin
          status_next = DQ_ST_FULL;
        end else begin
          status_next = DQ_ST_DONE;
          fill_next   = fill + 1'b1;
          we          = 1'b1;
          if (empty) begin
            // first word sits at the front index and both ends name it
            last_idx_next   = first_idx;
            waddr           = first_idx;
            front_word_next = wdata;
            back_word_next  = wdata;
          end else if (at_front) begin
            first_idx_next  = first_dec;
            waddr           = first_dec;
            front_word_next = wdata;
          end else begin
            last_idx_next  = last_inc;
            waddr          = last_inc;
            back_word_next = wdata;
          end
        end
      end else begin
        if (empty) begin
          status_next = DQ_ST_EMPTY;
        end else begin
          status_next = DQ_ST_DONE;
          fill_next   = fill - 1'b1;
          if (at_front) begin
            first_idx_next = first_inc;
          end else begin
            last_idx_next = last_dec;
          end
        end
      end
    end

    if (cmd.load) begin
      if (load_front) begin
        front_word_next = rdata;
      end else begin
        back_word_next = rdata;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      first_idx <= '0;
      last_idx  <= '0;
      fill      <= '0;
      status_q  <= DQ_ST_DONE;
    end else begin
      first_idx <= first_idx_next;
      last_idx  <= last_idx_next;
      fill      <= fill_next;
      status_q  <= status_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    front_word <= front_word_next;
    back_word  <= back_word_next;
    load_front <= load_front_next;
  end

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Result fields; end words read as zero when the queue is empty
  assign result.front_data = empty ? '0 : DQ_WORD_W'(front_word);
  assign result.back_data  = empty ? '0 : DQ_WORD_W'(back_word);
  assign result.occupancy  = DQ_OCC_W'(fill);
  assign result.is_empty   = empty;
  assign result.status     = status_q;

endmodule

`default_nettype wire

/* sv/double_ended_queue.sv */
// Top level of the bounded double-ended queue held in a ring of slots.
// Depends on dq_pkg, dq_ctrl, dq_datapath and dq_ram.
//
// Usage:
//   A request (func, entry_data) is taken at a rising edge where start is
//   high and busy is low. func selects push front, push back, pop front or
//   pop back; entry_data is used by pushes only.
//   Every request gives one result, shown on result for exactly one cycle
//   while done is high: front and back words, occupancy, empty flag and
//   status (done, push refused when full, pop refused when empty).
//   The receiver cannot stall; the result must be taken in that cycle.
//   done is high in the cycle right after the accept edge for
//   pushes, refused requests and pops that empty the queue. Pops that
//   leave one or more words pass through S_LOAD first, to read the new
//   end word through the registered RAM read port. busy falls at the edge
//   that ends done, so no new request is accepted until the result is out.
//   End words are cached in registers, so only such pops touch the read port.
//   Reset (rst, synchronous) empties the queue; slot contents are not
//   cleared and need no clearing pass, since only occupied slots are read.
`default_nettype none

module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH      = DQ_DEPTH,
  parameter int DATA_WIDTH = DQ_DATA_WIDTH
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  input  wire dq_req_t request,
  output logic         done,
  output dq_result_t   result
);

  dq_cmd_t  cmd;
  dq_stat_t stat;

  dq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  dq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result)
  );

endmodule

`default_nettype wire

/* sv/dq_checker.sv */
// Port-level checker for the double-ended queue and its bind statement.
// Depends on dq_pkg and double_ended_queue_macros.svh.
`default_nettype none
`include "double_ended_queue_macros.svh"

module dq_checker
  import dq_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire dq_req_t    request,
  input wire logic       done,
  input wire dq_result_t result
);

  logic accept;
  assign accept = start && !busy;

  // An accepted request holds the block busy until its result is out
  `DQ_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy)
  `DQ_ASSERT_IMPL(a_done_busy, clk, rst, done, busy)

  // Strobe lasts one cycle
  `DQ_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)

  // Empty result shows zero words and zero occupancy
  `DQ_ASSERT_IMPL(a_empty_zero, clk, rst, done && result.is_empty, (result.occupancy == '0) && (result.front_data == '0) && (result.back_data == '0))

  // A refused push means the queue holds words; a refused pop means it is empty
  `DQ_ASSERT_IMPL(a_refusal, clk, rst, done && (result.status != DQ_ST_DONE), (result.status == DQ_ST_FULL) ? !result.is_empty : result.is_empty)

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);

`default_nettype wire
